@@ rtl/core/qfp_pkg.sv @@
// ----------------------------------------------------------------------------
// qfp_pkg
// Shared types and constants of the QUIC frame parser: transfer structs,
// result kinds, error causes, frame type codes and length limits.
// ----------------------------------------------------------------------------
`default_nettype none

package qfp_pkg;

    // length limits
    localparam int unsigned STREAM_DATA_MAX = 4096;
    localparam int unsigned CRYPTO_DATA_MAX = 4096;
    localparam int unsigned REASON_MAX      = 256;
    localparam int unsigned CID_LEN_MAX     = 20;

    // bytes of the stateless reset token after a connection id
    localparam logic [15:0] RESET_TOKEN_LEN = 16'd16;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error causes
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_UNKNOWN   = 3'd1;
    localparam logic [2:0] CAUSE_TRUNC     = 3'd2;
    localparam logic [2:0] CAUSE_TOO_LONG  = 3'd3;
    localparam logic [2:0] CAUSE_EMPTY_TOK = 3'd4;
    localparam logic [2:0] CAUSE_BAD_CID   = 3'd5;
    localparam logic [2:0] CAUSE_REASON    = 3'd6;

    // frame type codes
    localparam logic [7:0] FT_PADDING     = 8'h00;
    localparam logic [7:0] FT_PING        = 8'h01;
    localparam logic [7:0] FT_ACK         = 8'h02;
    localparam logic [7:0] FT_ACK_ECN     = 8'h03;
    localparam logic [7:0] FT_CRYPTO      = 8'h06;
    localparam logic [7:0] FT_NEW_TOKEN   = 8'h07;
    localparam logic [7:0] FT_STREAM      = 8'h08;
    localparam logic [7:0] FT_STREAM_MASK = 8'hf8;
    localparam logic [7:0] FT_NEW_CID     = 8'h18;
    localparam logic [7:0] FT_CLOSE       = 8'h1c;
    localparam logic [7:0] FT_HS_DONE     = 8'h1e;

    // stream type bits
    localparam int unsigned STREAM_BIT_FIN = 0;
    localparam int unsigned STREAM_BIT_LEN = 1;
    localparam int unsigned STREAM_BIT_OFF = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_code;
        logic [61:0] first_value;
        logic [61:0] second_value;
        logic [12:0] payload_length;
        logic        fin_flag;
        logic [15:0] bytes_consumed;
        logic [2:0]  error_cause;
    } result_t;

    // results produced by one byte, slot 0 filled first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

`default_nettype wire

@@ rtl/core/qfp_parse.sv @@
// ----------------------------------------------------------------------------
// qfp_parse
// Frame parse state and its per-byte update: type decode, varint assembly,
// data pass-through, skip counters and error handling.
// ----------------------------------------------------------------------------
`default_nettype none

module qfp_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire qfp_pkg::item_t item,
    output qfp_pkg::push_t      push
);

    localparam logic [4:0] PH_TYPE        = 5'd0;
    localparam logic [4:0] PH_ACK_LARGEST = 5'd1;
    localparam logic [4:0] PH_ACK_DELAY   = 5'd2;
    localparam logic [4:0] PH_ACK_COUNT   = 5'd3;
    localparam logic [4:0] PH_ACK_FIRST   = 5'd4;
    localparam logic [4:0] PH_ACK_ECN     = 5'd5;
    localparam logic [4:0] PH_CR_OFF      = 5'd6;
    localparam logic [4:0] PH_CR_LEN      = 5'd7;
    localparam logic [4:0] PH_CR_DATA     = 5'd8;
    localparam logic [4:0] PH_TOK_LEN     = 5'd9;
    localparam logic [4:0] PH_TOK_SKIP    = 5'd10;
    localparam logic [4:0] PH_ST_ID       = 5'd11;
    localparam logic [4:0] PH_ST_OFF      = 5'd12;
    localparam logic [4:0] PH_ST_LEN      = 5'd13;
    localparam logic [4:0] PH_ST_DATA     = 5'd14;
    localparam logic [4:0] PH_ST_REST     = 5'd15;
    localparam logic [4:0] PH_NC_SEQ      = 5'd16;
    localparam logic [4:0] PH_NC_RET      = 5'd17;
    localparam logic [4:0] PH_NC_LEN      = 5'd18;
    localparam logic [4:0] PH_NC_SKIP     = 5'd19;
    localparam logic [4:0] PH_CC_CODE     = 5'd20;
    localparam logic [4:0] PH_CC_FTYPE    = 5'd21;
    localparam logic [4:0] PH_CC_LEN      = 5'd22;
    localparam logic [4:0] PH_CC_DATA     = 5'd23;

    localparam logic [1:0] GO_ON   = 2'd0;
    localparam logic [1:0] GO_DONE = 2'd1;
    localparam logic [1:0] GO_ERR  = 2'd2;

    localparam logic [61:0] CRYPTO_LIM = 62'(qfp_pkg::CRYPTO_DATA_MAX);
    localparam logic [61:0] STREAM_LIM = 62'(qfp_pkg::STREAM_DATA_MAX);
    localparam logic [61:0] REASON_LIM = 62'(qfp_pkg::REASON_MAX);
    localparam logic [15:0] REST_LIM   = 16'(qfp_pkg::STREAM_DATA_MAX);
    localparam logic [7:0]  CID_LIM    = 8'(qfp_pkg::CID_LEN_MAX);

    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  tb_reg, tb_next;
    logic [61:0] acc_reg, acc_next;
    logic [2:0]  vleft_reg, vleft_next;
    logic [61:0] hf_reg, hf_next;
    logic [61:0] hs_reg, hs_next;
    logic [15:0] br_reg, br_next;
    logic [15:0] fbc_reg, fbc_next;
    logic [1:0]  ecn_reg, ecn_next;
    logic        drop_reg, drop_next;

    logic [7:0]  b;
    logic        bend;
    logic [1:0]  go;
    logic [2:0]  cause;
    logic        pay;
    logic        at_rest;
    logic [61:0] v;
    logic [61:0] plen_src;
    logic        is_stream;
    qfp_pkg::result_t fin_res;
    qfp_pkg::result_t pay_res;

    assign b    = item.in_byte;
    assign bend = item.buffer_end;

    // per-byte state update
    always_comb
    begin
        phase_next = phase_reg;
        tb_next    = tb_reg;
        acc_next   = acc_reg;
        vleft_next = vleft_reg;
        hf_next    = hf_reg;
        hs_next    = hs_reg;
        br_next    = br_reg;
        fbc_next   = fbc_reg;
        ecn_next   = ecn_reg;
        drop_next  = drop_reg;
        go         = GO_ON;
        cause      = qfp_pkg::CAUSE_NONE;
        pay        = 1'b0;
        at_rest    = 1'b0;
        v          = '0;

        if (take && drop_reg)
        begin
            if (bend)
            begin
                drop_next  = 1'b0;
                phase_next = PH_TYPE;
            end
        end
        else if (take)
        begin
            fbc_next = (fbc_reg != 16'hffff) ? fbc_reg + 16'd1 : fbc_reg;
            unique case (phase_reg)
                PH_TYPE:
                begin
                    tb_next    = b;
                    hf_next    = '0;
                    hs_next    = '0;
                    acc_next   = '0;
                    vleft_next = '0;
                    br_next    = '0;
                    ecn_next   = '0;
                    fbc_next   = 16'd1;
                    if (b == qfp_pkg::FT_PADDING || b == qfp_pkg::FT_PING ||
                        b == qfp_pkg::FT_HS_DONE)
                        go = GO_DONE;
                    else if (b == qfp_pkg::FT_ACK || b == qfp_pkg::FT_ACK_ECN)
                    begin
                        ecn_next   = (b == qfp_pkg::FT_ACK_ECN) ? 2'd3 : 2'd0;
                        phase_next = PH_ACK_LARGEST;
                    end
                    else if (b == qfp_pkg::FT_CRYPTO)
                        phase_next = PH_CR_OFF;
                    else if (b == qfp_pkg::FT_NEW_TOKEN)
                        phase_next = PH_TOK_LEN;
                    else if ((b & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM)
                        phase_next = PH_ST_ID;
                    else if (b == qfp_pkg::FT_NEW_CID)
                        phase_next = PH_NC_SEQ;
                    else if (b == qfp_pkg::FT_CLOSE)
                        phase_next = PH_CC_CODE;
                    else
                    begin
                        cause = qfp_pkg::CAUSE_UNKNOWN;
                        go    = GO_ERR;
                    end
                end
                PH_CR_DATA, PH_ST_DATA, PH_CC_DATA:
                begin
                    pay     = 1'b1;
                    br_next = br_reg - 16'd1;
                    if (br_next == 16'd0)
                        go = GO_DONE;
                end
                PH_ST_REST:
                begin
                    if (br_reg >= REST_LIM)
                    begin
                        cause = qfp_pkg::CAUSE_TOO_LONG;
                        go    = GO_ERR;
                    end
                    else
                    begin
                        pay     = 1'b1;
                        br_next = br_reg + 16'd1;
                    end
                end
                PH_TOK_SKIP:
                begin
                    hs_next = hs_reg - 62'd1;
                    if (hs_next == 62'd0)
                        go = GO_DONE;
                end
                PH_NC_LEN:
                begin
                    if (b == 8'd0 || b > CID_LIM)
                    begin
                        cause = qfp_pkg::CAUSE_BAD_CID;
                        go    = GO_ERR;
                    end
                    else
                    begin
                        br_next    = {8'd0, b} + qfp_pkg::RESET_TOKEN_LEN;
                        phase_next = PH_NC_SKIP;
                    end
                end
                PH_NC_SKIP:
                begin
                    br_next = br_reg - 16'd1;
                    if (br_next == 16'd0)
                        go = GO_DONE;
                end
                default:
                begin
                    // varint assembly, big-endian with 2-bit length prefix
                    if (vleft_reg == 3'd0)
                    begin
                        acc_next = {56'd0, b[5:0]};
                        unique case (b[7:6])
                            2'd0:    vleft_next = 3'd0;
                            2'd1:    vleft_next = 3'd1;
                            2'd2:    vleft_next = 3'd3;
                            default: vleft_next = 3'd7;
                        endcase
                    end
                    else
                    begin
                        acc_next   = {acc_reg[53:0], b};
                        vleft_next = vleft_reg - 3'd1;
                    end
                    v = acc_next;
                    if (vleft_next == 3'd0)
                    begin
                        priority case (phase_reg)
                            PH_ACK_LARGEST:
                            begin
                                hf_next    = v;
                                phase_next = PH_ACK_DELAY;
                            end
                            PH_ACK_DELAY: phase_next = PH_ACK_COUNT;
                            PH_ACK_COUNT: phase_next = PH_ACK_FIRST;
                            PH_ACK_FIRST:
                            begin
                                if (ecn_reg == 2'd0)
                                    go = GO_DONE;
                                else
                                    phase_next = PH_ACK_ECN;
                            end
                            PH_ACK_ECN:
                            begin
                                ecn_next = ecn_reg - 2'd1;
                                if (ecn_next == 2'd0)
                                    go = GO_DONE;
                            end
                            PH_CR_OFF:
                            begin
                                hf_next    = v;
                                phase_next = PH_CR_LEN;
                            end
                            PH_CR_LEN:
                            begin
                                if (v > CRYPTO_LIM)
                                begin
                                    cause = qfp_pkg::CAUSE_TOO_LONG;
                                    go    = GO_ERR;
                                end
                                else if (v == 62'd0)
                                    go = GO_DONE;
                                else
                                begin
                                    br_next    = v[15:0];
                                    phase_next = PH_CR_DATA;
                                end
                            end
                            PH_TOK_LEN:
                            begin
                                if (v == 62'd0)
                                begin
                                    cause = qfp_pkg::CAUSE_EMPTY_TOK;
                                    go    = GO_ERR;
                                end
                                else
                                begin
                                    hs_next    = v;
                                    phase_next = PH_TOK_SKIP;
                                end
                            end
                            PH_ST_ID:
                            begin
                                hf_next = v;
                                if (tb_reg[qfp_pkg::STREAM_BIT_OFF])
                                    phase_next = PH_ST_OFF;
                                else if (tb_reg[qfp_pkg::STREAM_BIT_LEN])
                                    phase_next = PH_ST_LEN;
                                else
                                begin
                                    phase_next = PH_ST_REST;
                                    br_next    = '0;
                                end
                            end
                            PH_ST_OFF:
                            begin
                                hs_next = v;
                                if (tb_reg[qfp_pkg::STREAM_BIT_LEN])
                                    phase_next = PH_ST_LEN;
                                else
                                begin
                                    phase_next = PH_ST_REST;
                                    br_next    = '0;
                                end
                            end
                            PH_ST_LEN:
                            begin
                                if (v > STREAM_LIM)
                                begin
                                    cause = qfp_pkg::CAUSE_TOO_LONG;
                                    go    = GO_ERR;
                                end
                                else if (v == 62'd0)
                                    go = GO_DONE;
                                else
                                begin
                                    br_next    = v[15:0];
                                    phase_next = PH_ST_DATA;
                                end
                            end
                            PH_NC_SEQ: phase_next = PH_NC_RET;
                            PH_NC_RET: phase_next = PH_NC_LEN;
                            PH_CC_CODE:
                            begin
                                hf_next    = v;
                                phase_next = PH_CC_FTYPE;
                            end
                            PH_CC_FTYPE:
                            begin
                                hs_next    = v;
                                phase_next = PH_CC_LEN;
                            end
                            PH_CC_LEN:
                            begin
                                if (v > REASON_LIM)
                                begin
                                    cause = qfp_pkg::CAUSE_REASON;
                                    go    = GO_ERR;
                                end
                                else if (v == 62'd0)
                                    go = GO_DONE;
                                else
                                begin
                                    br_next    = v[15:0];
                                    phase_next = PH_CC_DATA;
                                end
                            end
                            default: go = GO_ON;
                        endcase
                    end
                end
            endcase

            // buffer end inside an unfinished frame
            if (go == GO_ON && bend)
            begin
                if (phase_next == PH_ST_REST)
                    go = GO_DONE;
                else
                begin
                    cause = qfp_pkg::CAUSE_TRUNC;
                    go    = GO_ERR;
                end
            end

            // stream running to buffer end, length comes from the data count
            at_rest = (phase_next == PH_ST_REST);

            if (go != GO_ON)
            begin
                phase_next = PH_TYPE;
                vleft_next = '0;
            end
            if (go == GO_ERR)
                drop_next = !bend;
        end
    end

    // frame summary fields
    always_comb
    begin
        is_stream = (tb_next & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM;
        if (at_rest)
            plen_src = {46'd0, br_next};
        else if (tb_next == qfp_pkg::FT_CRYPTO || tb_next == qfp_pkg::FT_CLOSE || is_stream)
            plen_src = acc_next;
        else
            plen_src = '0;

        pay_res              = '0;
        pay_res.result_kind  = qfp_pkg::KIND_PAYLOAD;
        pay_res.payload_byte = b;
        pay_res.frame_code   = tb_next;

        fin_res                = '0;
        fin_res.frame_code     = tb_next;
        fin_res.bytes_consumed = fbc_next;
        if (go == GO_DONE)
        begin
            fin_res.result_kind    = qfp_pkg::KIND_DONE;
            fin_res.first_value    = hf_next;
            fin_res.second_value   = hs_next;
            fin_res.payload_length = (|plen_src[61:13]) ? 13'h1fff : plen_src[12:0];
            fin_res.fin_flag       = is_stream & tb_next[qfp_pkg::STREAM_BIT_FIN];
        end
        else
        begin
            fin_res.result_kind = qfp_pkg::KIND_ERROR;
            fin_res.error_cause = cause;
        end

        push = '0;
        if (pay)
        begin
            push.valid0 = 1'b1;
            push.res0   = pay_res;
            push.valid1 = (go != GO_ON);
            push.res1   = fin_res;
        end
        else
        begin
            push.valid0 = (go != GO_ON);
            push.res0   = fin_res;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            tb_reg    <= '0;
            acc_reg   <= '0;
            vleft_reg <= '0;
            hf_reg    <= '0;
            hs_reg    <= '0;
            br_reg    <= '0;
            fbc_reg   <= '0;
            ecn_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tb_reg    <= tb_next;
            acc_reg   <= acc_next;
            vleft_reg <= vleft_next;
            hf_reg    <= hf_next;
            hs_reg    <= hs_next;
            br_reg    <= br_next;
            fbc_reg   <= fbc_next;
            ecn_reg   <= ecn_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qfp_res_queue.sv @@
// ----------------------------------------------------------------------------
// qfp_res_queue
// Four-entry result queue: takes up to two results per cycle, hands out one
// per transfer, and stalls the input side when fewer than two slots are free.
// ----------------------------------------------------------------------------
`default_nettype none

module qfp_res_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire qfp_pkg::push_t   push,
    output logic                  full,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output qfp_pkg::result_t      res_data
);

    qfp_pkg::result_t mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] n_push;

    assign res_valid = (cnt_reg != 3'd0);
    assign res_data  = mem[rd_reg];
    assign pop       = res_valid && !res_stall;
    assign full      = (cnt_reg > 3'd2);
    assign n_push    = {2'd0, push.valid0} + {2'd0, push.valid1};

    // pointer and fill count
    always_comb
    begin
        wr_next  = wr_reg + n_push[1:0];
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + n_push - {2'd0, pop};
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push.valid0)
            mem[wr_reg] <= push.res0;
        if (push.valid1)
            mem[wr_reg + 2'd1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/quic_frame_parser.sv @@
// ----------------------------------------------------------------------------
// quic_frame_parser
// Results: a byte's results are registered in the four-entry result queue.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; bytes that yield two results (last data
// byte of a frame) drain at one result per cycle through the result queue.
// Reset: asynchronous, clears parse state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quic_frame_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire qfp_pkg::item_t   src_data,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output qfp_pkg::result_t      res_data
);

    logic           full;
    logic           take;
    qfp_pkg::push_t push;

    // byte transfer when the queue has room for two results
    assign src_stall = full;
    assign take      = src_valid && !full;

    qfp_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (src_data),
        .push  (push)
    );

    qfp_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quic_frame_parser. A directed run of buffers covers
// every frame type but plain ACK, and every error cause. Random buffers then
// follow, mostly well-formed frames with random content, the rest noise and
// broken frames. A predictor inside a scoreboard class works out the expected
// result transfers of each accepted byte. Each received result is checked
// field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        PS_TYPE, PS_ACK_LARGEST, PS_ACK_DELAY, PS_ACK_COUNT, PS_ACK_FIRST, PS_ACK_ECN,
        PS_CR_OFF, PS_CR_LEN, PS_CR_DATA, PS_TOK_LEN, PS_TOK_SKIP, PS_ST_ID,
        PS_ST_OFF, PS_ST_LEN, PS_ST_DATA, PS_ST_REST, PS_NC_SEQ, PS_NC_RET,
        PS_NC_LEN, PS_NC_SKIP, PS_CC_CODE, PS_CC_FTYPE, PS_CC_LEN, PS_CC_DATA
    } phase_t;

    typedef enum int {STEP_ON, STEP_DONE, STEP_ERR} step_t;

    // frame parsing predictor with a queue of expected results
    class frame_scoreboard_t;
        phase_t      phase;
        logic [7:0]  ftype;
        logic [61:0] accum;
        logic [2:0]  vleft;
        logic [61:0] held1;
        logic [61:0] held2;
        logic [15:0] remain;
        logic [15:0] used;
        logic [1:0]  ecn;
        bit          dropping;
        qfp_pkg::result_t expected_q[$];
        int          errors;
        int          n_done;
        int          n_err;
        int          n_payload;

        function new();
            phase = PS_TYPE; ftype = '0; accum = '0; vleft = '0; held1 = '0;
            held2 = '0; remain = '0; used = '0; ecn = '0; dropping = 0;
            errors = 0; n_done = 0; n_err = 0; n_payload = 0;
        endfunction

        function bit is_stream();
            return (ftype & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM;
        endfunction

        function void push(logic [1:0] kind, logic [7:0] pb, logic [61:0] f1,
                           logic [61:0] f2, logic [63:0] plen, logic fin,
                           logic [2:0] cause);
            qfp_pkg::result_t r;
            r.result_kind    = kind;
            r.payload_byte   = pb;
            r.frame_code     = ftype;
            r.first_value    = f1;
            r.second_value   = f2;
            r.payload_length = plen > 64'd8191 ? 13'd8191 : plen[12:0];
            r.fin_flag       = fin;
            r.bytes_consumed = (kind == qfp_pkg::KIND_PAYLOAD) ? 16'd0 : used;
            r.error_cause    = cause;
            expected_q.push_back(r);
            if (kind == qfp_pkg::KIND_PAYLOAD) n_payload++;
            else if (kind == qfp_pkg::KIND_DONE) n_done++;
            else n_err++;
        endfunction

        function void stream_after_offset();
            if (ftype[qfp_pkg::STREAM_BIT_LEN]) phase = PS_ST_LEN;
            else begin
                phase = PS_ST_REST;
                remain = '0;
            end
        endfunction

        // act on a completed varint
        function step_t take_varint(logic [61:0] v, ref logic [2:0] cause);
            case (phase)
                PS_ACK_LARGEST: begin held1 = v; phase = PS_ACK_DELAY; end
                PS_ACK_DELAY: phase = PS_ACK_COUNT;
                PS_ACK_COUNT: phase = PS_ACK_FIRST;
                PS_ACK_FIRST: begin
                    if (ecn == 2'd0) return STEP_DONE;
                    phase = PS_ACK_ECN;
                end
                PS_ACK_ECN: begin
                    ecn = ecn - 2'd1;
                    if (ecn == 2'd0) return STEP_DONE;
                end
                PS_CR_OFF: begin held1 = v; phase = PS_CR_LEN; end
                PS_CR_LEN: begin
                    if (v > qfp_pkg::CRYPTO_DATA_MAX) begin
                        cause = qfp_pkg::CAUSE_TOO_LONG;
                        return STEP_ERR;
                    end
                    if (v == 62'd0) return STEP_DONE;
                    remain = v[15:0];
                    phase = PS_CR_DATA;
                end
                PS_TOK_LEN: begin
                    if (v == 62'd0) begin cause = qfp_pkg::CAUSE_EMPTY_TOK; return STEP_ERR; end
                    held2 = v;
                    phase = PS_TOK_SKIP;
                end
                PS_ST_ID: begin
                    held1 = v;
                    if (ftype[qfp_pkg::STREAM_BIT_OFF]) phase = PS_ST_OFF;
                    else stream_after_offset();
                end
                PS_ST_OFF: begin held2 = v; stream_after_offset(); end
                PS_ST_LEN: begin
                    if (v > qfp_pkg::STREAM_DATA_MAX) begin
                        cause = qfp_pkg::CAUSE_TOO_LONG;
                        return STEP_ERR;
                    end
                    if (v == 62'd0) return STEP_DONE;
                    remain = v[15:0];
                    phase = PS_ST_DATA;
                end
                PS_NC_SEQ: phase = PS_NC_RET;
                PS_NC_RET: phase = PS_NC_LEN;
                PS_CC_CODE: begin held1 = v; phase = PS_CC_FTYPE; end
                PS_CC_FTYPE: begin held2 = v; phase = PS_CC_LEN; end
                PS_CC_LEN: begin
                    if (v > qfp_pkg::REASON_MAX) begin
                        cause = qfp_pkg::CAUSE_REASON;
                        return STEP_ERR;
                    end
                    if (v == 62'd0) return STEP_DONE;
                    remain = v[15:0];
                    phase = PS_CC_DATA;
                end
                default: ;
            endcase
            return STEP_ON;
        endfunction

        function step_t take_type(logic [7:0] b, ref logic [2:0] cause);
            ftype = b; held1 = '0; held2 = '0; accum = '0; vleft = '0;
            remain = '0; ecn = '0; used = 16'd1;
            if (b == qfp_pkg::FT_PADDING || b == qfp_pkg::FT_PING ||
                b == qfp_pkg::FT_HS_DONE) return STEP_DONE;
            if (b == qfp_pkg::FT_ACK || b == qfp_pkg::FT_ACK_ECN) begin
                ecn = (b == qfp_pkg::FT_ACK_ECN) ? 2'd3 : 2'd0;
                phase = PS_ACK_LARGEST;
            end
            else if (b == qfp_pkg::FT_CRYPTO) phase = PS_CR_OFF;
            else if (b == qfp_pkg::FT_NEW_TOKEN) phase = PS_TOK_LEN;
            else if ((b & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM) phase = PS_ST_ID;
            else if (b == qfp_pkg::FT_NEW_CID) phase = PS_NC_SEQ;
            else if (b == qfp_pkg::FT_CLOSE) phase = PS_CC_CODE;
            else begin
                cause = qfp_pkg::CAUSE_UNKNOWN;
                return STEP_ERR;
            end
            return STEP_ON;
        endfunction

        // note an accepted input transfer
        function void note_input(qfp_pkg::item_t it);
            logic [7:0]  b;
            logic [2:0]  cause;
            logic [63:0] plen;
            step_t       go;
            b = it.in_byte;
            cause = qfp_pkg::CAUSE_NONE;
            go = STEP_ON;
            if (dropping) begin
                if (it.buffer_end) begin
                    dropping = 0;
                    phase = PS_TYPE;
                end
                return;
            end
            if (used != 16'hffff) used++;
            case (phase)
                PS_TYPE: go = take_type(b, cause);
                PS_CR_DATA, PS_ST_DATA, PS_CC_DATA: begin
                    push(qfp_pkg::KIND_PAYLOAD, b, '0, '0, '0, 1'b0, qfp_pkg::CAUSE_NONE);
                    remain = remain - 16'd1;
                    if (remain == 16'd0) go = STEP_DONE;
                end
                PS_ST_REST: begin
                    if (remain >= qfp_pkg::STREAM_DATA_MAX) begin
                        cause = qfp_pkg::CAUSE_TOO_LONG;
                        go = STEP_ERR;
                    end
                    else begin
                        push(qfp_pkg::KIND_PAYLOAD, b, '0, '0, '0, 1'b0,
                             qfp_pkg::CAUSE_NONE);
                        remain++;
                    end
                end
                PS_TOK_SKIP: begin
                    held2 = held2 - 62'd1;
                    if (held2 == 62'd0) go = STEP_DONE;
                end
                PS_NC_LEN: begin
                    if (b == 8'd0 || b > qfp_pkg::CID_LEN_MAX) begin
                        cause = qfp_pkg::CAUSE_BAD_CID;
                        go = STEP_ERR;
                    end
                    else begin
                        remain = {8'd0, b} + qfp_pkg::RESET_TOKEN_LEN;
                        phase = PS_NC_SKIP;
                    end
                end
                PS_NC_SKIP: begin
                    remain = remain - 16'd1;
                    if (remain == 16'd0) go = STEP_DONE;
                end
                default: begin
                    if (vleft == 3'd0) begin
                        accum = {56'd0, b[5:0]};
                        vleft = (3'd1 << b[7:6]) - 3'd1;
                    end
                    else begin
                        accum = {accum[53:0], b};
                        vleft = vleft - 3'd1;
                    end
                    if (vleft == 3'd0) go = take_varint(accum, cause);
                end
            endcase
            // buffer end inside an unfinished frame
            if (go == STEP_ON && it.buffer_end) begin
                if (phase == PS_ST_REST) go = STEP_DONE;
                else begin
                    cause = qfp_pkg::CAUSE_TRUNC;
                    go = STEP_ERR;
                end
            end
            if (go == STEP_DONE) begin
                plen = '0;
                if (phase == PS_ST_REST) plen = {48'd0, remain};
                else if (ftype == qfp_pkg::FT_CRYPTO || ftype == qfp_pkg::FT_CLOSE ||
                         is_stream()) plen = {2'd0, accum};
                push(qfp_pkg::KIND_DONE, 8'd0, held1, held2, plen,
                     is_stream() ? ftype[qfp_pkg::STREAM_BIT_FIN] : 1'b0,
                     qfp_pkg::CAUSE_NONE);
                phase = PS_TYPE;
                vleft = '0;
            end
            else if (go == STEP_ERR) begin
                push(qfp_pkg::KIND_ERROR, 8'd0, '0, '0, '0, 1'b0, cause);
                phase = PS_TYPE;
                vleft = '0;
                dropping = !it.buffer_end;
            end
        endfunction

        // check a received result transfer against the oldest expectation
        function void check_result(qfp_pkg::result_t got);
            qfp_pkg::result_t exp;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer %p", got);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.result_kind !== exp.result_kind) begin
                $error("result_kind exp %0d got %0d", exp.result_kind, got.result_kind);
                errors++;
            end
            if (got.payload_byte !== exp.payload_byte) begin
                $error("payload_byte exp %0h got %0h", exp.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.frame_code !== exp.frame_code) begin
                $error("frame_code exp %0h got %0h", exp.frame_code, got.frame_code);
                errors++;
            end
            if (got.first_value !== exp.first_value) begin
                $error("first_value exp %0h got %0h", exp.first_value, got.first_value);
                errors++;
            end
            if (got.second_value !== exp.second_value) begin
                $error("second_value exp %0h got %0h", exp.second_value, got.second_value);
                errors++;
            end
            if (got.payload_length !== exp.payload_length) begin
                $error("payload_length exp %0d got %0d", exp.payload_length,
                       got.payload_length);
                errors++;
            end
            if (got.fin_flag !== exp.fin_flag) begin
                $error("fin_flag exp %0d got %0d", exp.fin_flag, got.fin_flag);
                errors++;
            end
            if (got.bytes_consumed !== exp.bytes_consumed) begin
                $error("bytes_consumed exp %0d got %0d", exp.bytes_consumed,
                       got.bytes_consumed);
                errors++;
            end
            if (got.error_cause !== exp.error_cause) begin
                $error("error_cause exp %0d got %0d", exp.error_cause, got.error_cause);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    src_valid;
    logic    src_stall;
    qfp_pkg::item_t   src_data;
    logic    res_valid;
    logic    res_stall;
    qfp_pkg::result_t res_data;

    frame_scoreboard_t sb;
    int  src_idle_pct;
    int  res_idle_pct;
    int  idle_cycles;
    int  n_bytes;
    bit  timed_out;
    byte unsigned buf_q[$];

    quic_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // monitor: note input transfers, check result transfers
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (src_valid && !src_stall) begin
                sb.note_input(src_data);
                n_bytes++;
            end
            if (res_valid && !res_stall) sb.check_result(res_data);
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (!rst_n) res_stall <= 1'b0;
        else res_stall <= ($urandom_range(99) < res_idle_pct);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            timed_out = 1;
            $display("Verification failed");
            $finish;
        end
    end

    // send one byte; valid stays high across back-to-back transfers
    task automatic send_byte(byte unsigned b, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{in_byte: b, buffer_end: last};
        do @(posedge clk); while (src_stall);
    endtask

    // send the collected buffer, marking its last byte
    task automatic send_buffer();
        foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // append a varint in the given encoding length class
    task automatic add_varint(longint unsigned v, int lc);
        int nb;
        nb = 1 << lc;
        for (int i = nb - 1; i >= 0; i--) begin
            byte unsigned b;
            b = 8'(v >> (8 * i));
            if (i == nb - 1) b = {lc[1:0], b[5:0]};
            buf_q.push_back(b);
        end
    endtask

    function automatic longint unsigned rand_val(int lc);
        longint unsigned v;
        v = {$urandom, $urandom};
        case (lc)
            0: return v & 64'h3f;
            1: return v & 64'h3fff;
            2: return v & 64'h3fff_ffff;
            default: return v & 64'h3fff_ffff_ffff_ffff;
        endcase
    endfunction

    task automatic add_rand_varint();
        int lc;
        lc = $urandom_range(3);
        add_varint(rand_val(lc), lc);
    endtask

    // minimal encoding class for a small length
    function automatic int len_class(longint unsigned v);
        if (v < 64) return 0;
        if (v < 16384) return 1;
        return 2;
    endfunction

    task automatic add_len(longint unsigned v);
        add_varint(v, ($urandom_range(3) == 0) ? 2 : len_class(v));
    endtask

    task automatic add_data(int n);
        repeat (n) buf_q.push_back(8'($urandom_range(255)));
    endtask

    // one well-formed frame of the given type with random content
    task automatic add_frame(byte unsigned t, int dlen);
        buf_q.push_back(t);
        case (t)
            qfp_pkg::FT_ACK, qfp_pkg::FT_ACK_ECN: begin
                repeat (4) add_rand_varint();
                if (t == qfp_pkg::FT_ACK_ECN) repeat (3) add_rand_varint();
            end
            qfp_pkg::FT_CRYPTO, qfp_pkg::FT_CLOSE: begin
                add_rand_varint();
                if (t == qfp_pkg::FT_CLOSE) add_rand_varint();
                add_len(dlen);
                add_data(dlen);
            end
            qfp_pkg::FT_NEW_TOKEN: begin
                add_len(dlen);
                add_data(dlen);
            end
            qfp_pkg::FT_NEW_CID: begin
                add_rand_varint();
                add_rand_varint();
                buf_q.push_back(8'(dlen));
                add_data(dlen + 16);
            end
            default: begin
                if ((t & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM) begin
                    add_rand_varint();
                    if (t[qfp_pkg::STREAM_BIT_OFF]) add_rand_varint();
                    if (t[qfp_pkg::STREAM_BIT_LEN]) add_len(dlen);
                    add_data(dlen);
                end
            end
        endcase
    endtask

    function automatic byte unsigned rand_type();
        case ($urandom_range(9))
            0: return qfp_pkg::FT_PADDING;
            1: return ($urandom_range(1)) ? qfp_pkg::FT_PING : qfp_pkg::FT_HS_DONE;
            2: return qfp_pkg::FT_ACK;
            3: return qfp_pkg::FT_ACK_ECN;
            4: return qfp_pkg::FT_CRYPTO;
            5: return qfp_pkg::FT_NEW_TOKEN;
            6: return qfp_pkg::FT_NEW_CID;
            7: return qfp_pkg::FT_CLOSE;
            default: return qfp_pkg::FT_STREAM | 8'($urandom_range(7));
        endcase
    endfunction

    function automatic int rand_dlen(byte unsigned t);
        if (t == qfp_pkg::FT_NEW_CID) return $urandom_range(1, qfp_pkg::CID_LEN_MAX);
        if ($urandom_range(19) == 0) return $urandom_range(0, 40);
        return $urandom_range(1, 6);
    endfunction

    // one random buffer: frames, sometimes cut, broken or noisy
    task automatic random_buffer();
        int nf;
        byte unsigned t;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            t = rand_type();
            // a stream without length must be the last frame
            if ((t & qfp_pkg::FT_STREAM_MASK) == qfp_pkg::FT_STREAM &&
                !t[qfp_pkg::STREAM_BIT_LEN] && f != nf - 1)
                t[qfp_pkg::STREAM_BIT_LEN] = 1'b1;
            add_frame(t, (t == qfp_pkg::FT_NEW_TOKEN) ? $urandom_range(1, 6) : rand_dlen(t));
        end
        case ($urandom_range(9))
            0: if (buf_q.size() > 1) buf_q = buf_q[0:$urandom_range(buf_q.size() - 2)];
            1: buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom_range(255));
            2: begin
                buf_q.delete();
                add_data($urandom_range(1, 8));
            end
            default: ;
        endcase
        send_buffer();
    endtask

    // directed buffers: each frame type but plain ACK, extremes and every error cause
    task automatic directed();
        add_frame(qfp_pkg::FT_PADDING, 0); add_frame(qfp_pkg::FT_PING, 0);
        add_frame(qfp_pkg::FT_HS_DONE, 0);
        send_buffer();
        buf_q.push_back(qfp_pkg::FT_ACK_ECN);
        add_varint(64'h3fff_ffff_ffff_ffff, 3);
        add_varint(0, 0); add_varint(0, 0); add_varint(63, 0);
        add_varint(1, 1); add_varint(2, 2); add_varint(3, 3);
        send_buffer();
        add_frame(qfp_pkg::FT_CRYPTO, 3); add_frame(qfp_pkg::FT_CRYPTO, 0); send_buffer();
        add_frame(qfp_pkg::FT_NEW_TOKEN, 2); add_frame(8'h0f, 3); send_buffer();
        add_frame(8'h0d, 2); send_buffer();                  // stream to buffer end
        add_frame(8'h08, 0); send_buffer();                  // empty stream at end
        buf_q.push_back(8'h0c); add_varint(5, 0); add_varint(9, 0);
        send_buffer();                                       // no data bytes at all
        buf_q.push_back(8'h08); add_varint(7, 0);
        send_buffer();                                       // stream id then end
        add_frame(qfp_pkg::FT_NEW_CID, qfp_pkg::CID_LEN_MAX); add_frame(qfp_pkg::FT_CLOSE, 4);
        send_buffer();
        add_frame(qfp_pkg::FT_CLOSE, 0); add_frame(qfp_pkg::FT_NEW_CID, 1); send_buffer();
        buf_q.push_back(8'hff); add_data(3); send_buffer();  // unknown type
        buf_q.push_back(qfp_pkg::FT_CRYPTO); add_varint(0, 0);
        add_varint(qfp_pkg::CRYPTO_DATA_MAX + 1, 1);
        add_data(2); send_buffer();
        buf_q.push_back(8'h0a); add_varint(0, 0);
        add_varint(qfp_pkg::STREAM_DATA_MAX + 1, 1);
        send_buffer();
        buf_q.push_back(qfp_pkg::FT_NEW_TOKEN); add_varint(0, 0); add_data(2); send_buffer();
        buf_q.push_back(qfp_pkg::FT_NEW_CID); add_varint(0, 0); add_varint(0, 0);
        buf_q.push_back(8'h00); send_buffer();
        buf_q.push_back(qfp_pkg::FT_NEW_CID); add_varint(0, 0); add_varint(0, 0);
        buf_q.push_back(8'(qfp_pkg::CID_LEN_MAX + 1)); send_buffer();
        buf_q.push_back(qfp_pkg::FT_CLOSE); add_varint(1, 0); add_varint(2, 0);
        add_varint(qfp_pkg::REASON_MAX + 1, 1); send_buffer();
        buf_q.push_back(qfp_pkg::FT_CRYPTO); add_varint(1, 0); add_varint(4, 0); add_data(2);
        send_buffer();                                       // truncated in data
        drain();
        // stream without length passing its data limit
        buf_q.push_back(8'h08); add_varint(0, 0); add_data(qfp_pkg::STREAM_DATA_MAX + 2);
        send_buffer();
        // long token near its length maximum only in the length field
        buf_q.push_back(qfp_pkg::FT_NEW_TOKEN); add_varint(64'h3fff_ffff_ffff_ffff, 3);
        add_data(4); send_buffer();
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        res_stall = 1'b0;
        src_idle_pct = 38;
        res_idle_pct = 38;
        idle_cycles = 0;
        n_bytes = 0;
        timed_out = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int k = 0; n_bytes < 1200 + 4200; k++) begin
            // a stretch with no idling on either side
            src_idle_pct = (k >= 40 && k < 70) ? 0 : 38;
            res_idle_pct = src_idle_pct;
            random_buffer();
            if (k == 100) drain();
        end
        drain();
        $display("Covered %0d bytes: %0d completed frames, %0d errors, %0d payload bytes.",
                 n_bytes, sb.n_done, sb.n_err, sb.n_payload);
        if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ quic_frame_parser.f @@
rtl/core/qfp_pkg.sv
rtl/core/qfp_parse.sv
rtl/core/qfp_res_queue.sv
rtl/core/quic_frame_parser.sv
tb/tb_top.sv
